### hw/rtl/omo_pkg.sv
// shared types, constants and arithmetic helpers for the omni wheel odometry block
`timescale 1ns / 1ps
package omo_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [15:0] RADIUS_RESET = 16'd13107;
    localparam logic [15:0] BASE_RESET   = 16'd6554;
    localparam logic [15:0] DT_RESET     = 16'd3277;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_DT     = 2'd2;

    localparam logic signed [34:0] INV_SQRT3    = 35'sd37837;
    localparam logic signed [34:0] INV_2PI      = 35'sd683565276;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    // vy divides by 768 = 3 * 256: round, drop 8 bits, then times ceil(2^28 / 3)
    localparam logic [33:0]        VY_HALF    = 34'd384;
    localparam int                 VY_SHIFT   = 8;
    localparam logic signed [34:0] INV3_Q28   = 35'sd89478486;
    localparam int                 INV3_SHIFT = 28;

    // dividend width of the serial divider
    localparam int DIVW  = 44;
    localparam int DCNTW = $clog2(DIVW + 1);

    localparam int OPW = 5;
    localparam logic [OPW-1:0] OP_NONE = 5'd0;
    localparam logic [OPW-1:0] OP_LOAD = 5'd1;
    localparam logic [OPW-1:0] OP_MR   = 5'd2;
    localparam logic [OPW-1:0] OP_MK   = 5'd3;
    localparam logic [OPW-1:0] OP_VX   = 5'd4;
    localparam logic [OPW-1:0] OP_DVY  = 5'd5;
    localparam logic [OPW-1:0] OP_VY   = 5'd6;
    localparam logic [OPW-1:0] OP_DWZ  = 5'd7;
    localparam logic [OPW-1:0] OP_WZ   = 5'd8;
    localparam logic [OPW-1:0] OP_MT   = 5'd9;
    localparam logic [OPW-1:0] OP_P16  = 5'd10;
    localparam logic [OPW-1:0] OP_MA   = 5'd11;
    localparam logic [OPW-1:0] OP_ANG  = 5'd12;
    localparam logic [OPW-1:0] OP_C1   = 5'd13;
    localparam logic [OPW-1:0] OP_C2   = 5'd14;
    localparam logic [OPW-1:0] OP_C3   = 5'd15;
    localparam logic [OPW-1:0] OP_C4   = 5'd16;
    localparam logic [OPW-1:0] OP_C5   = 5'd17;
    localparam logic [OPW-1:0] OP_C6   = 5'd18;
    localparam logic [OPW-1:0] OP_DONE = 5'd19;
    localparam logic [OPW-1:0] OP_MVY  = 5'd20;

    typedef struct packed {
        logic [OPW-1:0] op;
    } omo_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic cor_done;
    } omo_status_t;

    // arctangent of 2^-k as a fraction of a 32 bit turn
    function automatic logic signed [33:0] atan_turn(input logic [4:0] k);
        logic signed [33:0] a;
        case (k)
            5'd0:  a = 34'sd536870912;
            5'd1:  a = 34'sd316933406;
            5'd2:  a = 34'sd167458907;
            5'd3:  a = 34'sd85004756;
            5'd4:  a = 34'sd42667331;
            5'd5:  a = 34'sd21354465;
            5'd6:  a = 34'sd10679838;
            5'd7:  a = 34'sd5340245;
            5'd8:  a = 34'sd2670163;
            5'd9:  a = 34'sd1335087;
            5'd10: a = 34'sd667544;
            5'd11: a = 34'sd333772;
            5'd12: a = 34'sd166886;
            5'd13: a = 34'sd83443;
            5'd14: a = 34'sd41722;
            5'd15: a = 34'sd20861;
            5'd16: a = 34'sd10430;
            5'd17: a = 34'sd5215;
            5'd18: a = 34'sd2608;
            5'd19: a = 34'sd1304;
            5'd20: a = 34'sd652;
            5'd21: a = 34'sd326;
            5'd22: a = 34'sd163;
            5'd23: a = 34'sd81;
            5'd24: a = 34'sd41;
            5'd25: a = 34'sd20;
            5'd26: a = 34'sd10;
            5'd27: a = 34'sd5;
            5'd28: a = 34'sd3;
            5'd29: a = 34'sd1;
            5'd30: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    // shift right by s with rounding to nearest, ties away from zero
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                   input int unsigned s);
        logic [71:0] mag;
        logic [71:0] q;
        mag = v[71] ? 72'(-v) : 72'(v);
        q   = (mag + (72'd1 << (s - 1))) >> s;
        return v[71] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/omni_wheel_odometry_top.sv
// top level of the omni wheel odometry block: apb registers, sequencer and datapath
`timescale 1ns / 1ps
// usage
// - s_ channel: one request carries three signed q7.8 wheel speeds; the block
//   takes a request only while idle, then works on it alone
// - m_ channel: one result per request with body velocity, yaw rate and the
//   updated pose; the result sits in an output register so the next request
//   can be taken while it waits
// - apb port: radius at 0x0, base distance at 0x4, step time at 0x8,
//   16 bit values, write only while idle
// - timing: the yaw rate comes from the serial divider, one bit a cycle,
//   and the heading from the cordic at one step a cycle
// - a new request is taken only once the last result is registered and the
//   sequencer is back in idle
// - reset clears the pose, the heading and the registers to their defaults
// - a stalled receiver holds the result; the block finishes the next request
//   and then waits until the output register frees
module omni_wheel_odometry_top #(
    parameter int ANGLE_BITS   = omo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = omo_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // apb configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    // wheel0_speed, wheel1_speed, wheel2_speed
    input  logic [47:0]  s_tdata,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // vel_x, vel_y, yaw_rate, pose_x, pose_y, pose_heading
    output logic [175:0] m_tdata
);
    import omo_pkg::*;

    logic [15:0] radius_reg;
    logic [15:0] base_reg;
    logic [15:0] dt_reg;
    logic        wr_en;

    omo_cmd_t    cmd;
    omo_status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes, upper data bits dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            base_reg   <= BASE_RESET;
            dt_reg     <= DT_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[15:0];
                REG_BASE:   base_reg   <= pwdata[15:0];
                REG_DT:     dt_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // readback, unknown address reads zero
    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {16'd0, radius_reg};
            REG_BASE:   prdata = {16'd0, base_reg};
            REG_DT:     prdata = {16'd0, dt_reg};
            default:    prdata = '0;
        endcase
    end

    omo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    omo_dp #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .radius_q16   (radius_reg),
        .base_q16     (base_reg),
        .step_time    (dt_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

    // a taken request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block ready right after taking a request");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while still busy");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without work");

endmodule

### hw/rtl/omo_ctrl.sv
// sequencer that steps the odometry datapath through one item
`timescale 1ns / 1ps
module omo_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  omo_pkg::omo_status_t status,
    output omo_pkg::omo_cmd_t    cmd
);
    import omo_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_MR   = 5'd1;
    localparam logic [4:0] ST_MK   = 5'd2;
    localparam logic [4:0] ST_VX   = 5'd3;
    localparam logic [4:0] ST_DVY  = 5'd4;
    localparam logic [4:0] ST_MVY  = 5'd5;
    localparam logic [4:0] ST_VY   = 5'd6;
    localparam logic [4:0] ST_DWZ  = 5'd7;
    localparam logic [4:0] ST_WWZ  = 5'd8;
    localparam logic [4:0] ST_WZ   = 5'd9;
    localparam logic [4:0] ST_MT   = 5'd10;
    localparam logic [4:0] ST_P16  = 5'd11;
    localparam logic [4:0] ST_MA   = 5'd12;
    localparam logic [4:0] ST_ANG  = 5'd13;
    localparam logic [4:0] ST_WCOR = 5'd14;
    localparam logic [4:0] ST_C1   = 5'd15;
    localparam logic [4:0] ST_C2   = 5'd16;
    localparam logic [4:0] ST_C3   = 5'd17;
    localparam logic [4:0] ST_C4   = 5'd18;
    localparam logic [4:0] ST_C5   = 5'd19;
    localparam logic [4:0] ST_C6   = 5'd20;
    localparam logic [4:0] ST_DONE = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_MR;
                end
            end
            ST_MR:   begin cmd.op = OP_MR;  state_next = ST_MK;  end
            ST_MK:   begin cmd.op = OP_MK;  state_next = ST_VX;  end
            ST_VX:   begin cmd.op = OP_VX;  state_next = ST_DVY; end
            ST_DVY:  begin cmd.op = OP_DVY; state_next = ST_MVY; end
            ST_MVY:  begin cmd.op = OP_MVY; state_next = ST_VY;  end
            ST_VY:   begin cmd.op = OP_VY;  state_next = ST_DWZ; end
            ST_DWZ:  begin cmd.op = OP_DWZ; state_next = ST_WWZ; end
            ST_WWZ: begin
                if (status.div_done) state_next = ST_WZ;
            end
            ST_WZ:   begin cmd.op = OP_WZ;  state_next = ST_MT;  end
            ST_MT:   begin cmd.op = OP_MT;  state_next = ST_P16; end
            ST_P16:  begin cmd.op = OP_P16; state_next = ST_MA;  end
            ST_MA:   begin cmd.op = OP_MA;  state_next = ST_ANG; end
            ST_ANG:  begin cmd.op = OP_ANG; state_next = ST_WCOR; end
            ST_WCOR: begin
                if (status.cor_done) state_next = ST_C1;
            end
            ST_C1:   begin cmd.op = OP_C1;  state_next = ST_C2;  end
            ST_C2:   begin cmd.op = OP_C2;  state_next = ST_C3;  end
            ST_C3:   begin cmd.op = OP_C3;  state_next = ST_C4;  end
            ST_C4:   begin cmd.op = OP_C4;  state_next = ST_C5;  end
            ST_C5:   begin cmd.op = OP_C5;  state_next = ST_C6;  end
            ST_C6:   begin cmd.op = OP_C6;  state_next = ST_DONE; end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/omo_dp.sv
// datapath: shared multiplier, serial divider, cordic and pose registers
`timescale 1ns / 1ps
module omo_dp #(
    parameter int ANGLE_BITS   = omo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = omo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  omo_pkg::omo_cmd_t    cmd,
    output omo_pkg::omo_status_t status,
    input  logic [47:0]          s_tdata,
    input  logic [15:0]          radius_q16,
    input  logic [15:0]          base_q16,
    input  logic [15:0]          step_time,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [175:0]         m_tdata
);
    import omo_pkg::*;

    localparam int CCNTW = $clog2(CORDIC_STEPS + 1);

    logic signed [16:0] d02_reg;
    logic signed [17:0] e_reg;
    logic signed [17:0] sum_reg;
    logic signed [69:0] prod_reg;
    logic signed [69:0] acc_reg;
    logic signed [31:0] vx_reg, vy_reg, wz_reg;
    logic signed [32:0] p16_reg;
    logic signed [34:0] gx_reg, gy_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [ANGLE_BITS-1:0] heading_reg;
    logic [ANGLE_BITS-1:0] dyaw_reg;
    logic [24:0]        vt_reg;
    logic               vneg_reg;

    logic signed [34:0] ma, mb;
    logic               mul_en;
    logic signed [34:0] r_s, dt_s;
    logic signed [33:0] cs, sn;
    logic [33:0]        vmag;
    logic signed [71:0] vy_full;

    assign r_s  = $signed({19'd0, radius_q16});
    assign dt_s = $signed({19'd0, step_time});

    // operand selection for the shared multiplier
    always_comb begin
        ma     = '0;
        mb     = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MR:  begin ma = 35'(d02_reg);      mb = r_s;           end
            OP_MK:  begin ma = prod_reg[34:0];    mb = INV_SQRT3;     end
            OP_VX:  begin ma = 35'(e_reg);        mb = r_s;           end
            OP_MVY: begin ma = 35'(vt_reg);       mb = INV3_Q28;      end
            OP_VY:  begin ma = 35'(sum_reg);      mb = r_s;           end
            OP_MT:  begin ma = 35'(wz_reg);       mb = dt_s;          end
            OP_MA:  begin ma = 35'(p16_reg);      mb = INV_2PI;       end
            OP_C1:  begin ma = 35'(cs);           mb = 35'(vx_reg);   end
            OP_C2:  begin ma = 35'(sn);           mb = 35'(vy_reg);   end
            OP_C3:  begin ma = 35'(sn);           mb = 35'(vx_reg);   end
            OP_C4:  begin ma = 35'(cs);           mb = 35'(vy_reg);   end
            OP_C5:  begin ma = gx_reg;            mb = dt_s;          end
            OP_C6:  begin ma = gy_reg;            mb = dt_s;          end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) prod_reg <= ma * mb;
    end

    // vy: magnitude rounded and scaled by 1/256 here, the divide by 3 on the multiplier
    assign vmag    = prod_reg[69] ? 34'(-prod_reg) : 34'(prod_reg);
    assign vy_full = vneg_reg ? -72'(prod_reg >>> INV3_SHIFT)
                              : 72'(prod_reg >>> INV3_SHIFT);

    // serial restoring divider for the yaw rate, one quotient bit per cycle
    logic [DIVW-1:0]    dvd_reg;
    logic [17:0]        rem_reg;
    logic [17:0]        den_reg;
    logic               dneg_reg;
    logic               dbusy_reg;
    logic [DCNTW-1:0]   dcnt_reg;
    logic [18:0]        dtrial;
    logic signed [71:0] dnum;
    logic [DIVW-1:0]    dmag;
    logic [17:0]        dden;
    logic [15:0]        base_eff;
    logic signed [71:0] quot;

    assign base_eff = (base_q16 == 16'd0) ? 16'd1 : base_q16;
    assign dtrial   = {rem_reg, dvd_reg[DIVW-1]};
    assign quot     = dneg_reg ? -$signed({28'd0, dvd_reg}) : $signed({28'd0, dvd_reg});
    assign dnum     = -(72'(prod_reg) <<< 8);
    assign dden     = 18'(18'd3 * 18'(base_eff));
    assign dmag     = dnum[71] ? DIVW'(-dnum) : DIVW'(dnum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.op == OP_DWZ) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DCNTW'(DIVW);
            dvd_reg   <= dmag + DIVW'(dden >> 1);
            rem_reg   <= '0;
            den_reg   <= dden;
            dneg_reg  <= dnum[71];
        end else if (dbusy_reg) begin
            if (dtrial >= {1'b0, den_reg}) begin
                rem_reg <= 18'(dtrial - {1'b0, den_reg});
                dvd_reg <= {dvd_reg[DIVW-2:0], 1'b1};
            end else begin
                rem_reg <= dtrial[17:0];
                dvd_reg <= {dvd_reg[DIVW-2:0], 1'b0};
            end
            dcnt_reg  <= dcnt_reg - 1'b1;
            dbusy_reg <= (dcnt_reg != DCNTW'(1));
        end
    end

    // cordic rotation, one step per cycle
    logic signed [33:0]    cx_reg, cy_reg, cz_reg;
    logic                  cflip_reg;
    logic                  cbusy_reg;
    logic [CCNTW-1:0]      ccnt_reg;
    logic [4:0]            ck;
    logic signed [71:0]    hd_full;
    logic signed [71:0]    dy_full;
    logic [ANGLE_BITS-1:0] mid;
    logic [31:0]           turn32;
    logic signed [33:0]    zs;

    assign ck      = 5'(ccnt_reg);
    assign cs      = cflip_reg ? -cx_reg : cx_reg;
    assign sn      = cflip_reg ? -cy_reg : cy_reg;
    assign hd_full = rnd_shr(72'(prod_reg), 49 - ANGLE_BITS);
    assign dy_full = rnd_shr(72'(prod_reg), 48 - ANGLE_BITS);
    assign mid     = heading_reg + hd_full[ANGLE_BITS-1:0];
    assign turn32  = 32'(mid) << (32 - ANGLE_BITS);
    assign zs      = 34'($signed(turn32));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cbusy_reg <= 1'b0;
            ccnt_reg  <= '0;
        end else if (cmd.op == OP_ANG) begin
            cbusy_reg <= 1'b1;
            ccnt_reg  <= '0;
            cx_reg    <= CORDIC_START;
            cy_reg    <= '0;
            if (zs > 34'sh40000000) begin
                cz_reg    <= zs - 34'sh80000000;
                cflip_reg <= 1'b1;
            end else if (zs < -34'sh40000000) begin
                cz_reg    <= zs + 34'sh80000000;
                cflip_reg <= 1'b1;
            end else begin
                cz_reg    <= zs;
                cflip_reg <= 1'b0;
            end
        end else if (cbusy_reg) begin
            if (cz_reg >= 0) begin
                cx_reg <= cx_reg - (cy_reg >>> ck);
                cy_reg <= cy_reg + (cx_reg >>> ck);
                cz_reg <= cz_reg - atan_turn(ck);
            end else begin
                cx_reg <= cx_reg + (cy_reg >>> ck);
                cy_reg <= cy_reg - (cx_reg >>> ck);
                cz_reg <= cz_reg + atan_turn(ck);
            end
            ccnt_reg  <= ccnt_reg + 1'b1;
            cbusy_reg <= (ccnt_reg != CCNTW'(CORDIC_STEPS - 1));
        end
    end

    // item registers and pose state
    logic signed [15:0]     w0, w1, w2;
    logic signed [31:0]     py_new;
    logic [ANGLE_BITS-1:0]  heading_new;
    logic [ANGLE_BITS+15:0] head_wide;
    logic                   m_valid_reg;

    assign w0          = $signed(s_tdata[15:0]);
    assign w1          = $signed(s_tdata[31:16]);
    assign w2          = $signed(s_tdata[47:32]);
    assign py_new      = sat32(72'(py_reg) + rnd_shr(72'(prod_reg), 16));
    assign heading_new = heading_reg + dyaw_reg;
    assign head_wide   = {heading_new, 16'd0};

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                d02_reg <= 17'(w0) - 17'(w2);
                e_reg   <= 18'(w1) + 18'(w1) - 18'(w0) - 18'(w2);
                sum_reg <= 18'(w0) + 18'(w1) + 18'(w2);
            end
            OP_VX:  vx_reg  <= sat32(rnd_shr(72'(prod_reg), 24));
            OP_DVY: begin
                vt_reg   <= 25'((vmag + VY_HALF) >> VY_SHIFT);
                vneg_reg <= prod_reg[69];
            end
            OP_VY:  vy_reg  <= sat32(vy_full);
            OP_WZ:  wz_reg  <= sat32(quot);
            OP_P16: p16_reg <= 33'(rnd_shr(72'(prod_reg), 16));
            OP_ANG: dyaw_reg <= dy_full[ANGLE_BITS-1:0];
            OP_C2:  acc_reg <= prod_reg;
            OP_C3:  gx_reg  <= 35'(rnd_shr(72'(acc_reg) - 72'(prod_reg), 30));
            OP_C4:  acc_reg <= prod_reg;
            OP_C5:  gy_reg  <= 35'(rnd_shr(72'(acc_reg) + 72'(prod_reg), 30));
            OP_DONE: begin
                m_tdata <= {head_wide[ANGLE_BITS+15:ANGLE_BITS], py_new, px_reg,
                            wz_reg, vy_reg, vx_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg      <= '0;
            py_reg      <= '0;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_C6) begin
                px_reg <= sat32(72'(px_reg) + rnd_shr(72'(prod_reg), 16));
            end
            if (cmd.op == OP_DONE) begin
                py_reg      <= py_new;
                heading_reg <= heading_new;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign status.out_free = !m_valid_reg || m_tready;
    assign status.div_done = !dbusy_reg;
    assign status.cor_done = !cbusy_reg;

endmodule
